>>> hdl/vsc_pkg.sv
// vsc_pkg: shared types and constants for the version string checker
// no dependencies; used by vsc_parser and version_string_checker
`timescale 1ns / 1ps

package vsc_pkg;

   localparam int CHAR_W  = 8;
   localparam int PHASE_W = 4;

   // parse phase codes
   localparam logic [PHASE_W-1:0] PH_MAJ_FIRST = 4'd0;
   localparam logic [PHASE_W-1:0] PH_MAJ_MORE  = 4'd1;
   localparam logic [PHASE_W-1:0] PH_MIN_FIRST = 4'd2;
   localparam logic [PHASE_W-1:0] PH_MIN_MORE  = 4'd3;
   localparam logic [PHASE_W-1:0] PH_PAT_FIRST = 4'd4;
   localparam logic [PHASE_W-1:0] PH_PAT_MORE  = 4'd5;
   localparam logic [PHASE_W-1:0] PH_SUF_FIRST = 4'd6;
   localparam logic [PHASE_W-1:0] PH_SUF_MORE  = 4'd7;
   localparam logic [PHASE_W-1:0] PH_ERROR     = 4'd8;

   // character constants
   localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2e;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2b;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5a;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;

   // one byte stepping through the parser
   typedef struct packed {
      logic              step;
      logic [CHAR_W-1:0] ch;
   } vsc_step_type;

endpackage

>>> hdl/version_string_checker.sv
// version_string_checker: top level with input register, parser and result register
// depends on vsc_pkg and vsc_parser
`timescale 1ns / 1ps

// Checks a MAJOR.MINOR.PATCH version string, with an optional '-' or '+'
// suffix, that arrives one byte per transfer on req_; a zero byte ends the
// string and produces one transfer on rsp_ whose bit 0 is 1 for a valid
// string. Other bytes produce no result. One byte is taken every cycle while
// no terminator is held in the input register by a full result register; each
// byte is registered in the input register, and a terminator's verdict is then
// loaded into the result register. Only a terminator waits on a full result
// register; bytes keep flowing while a verdict is pending as long as no second
// terminator arrives. The parser returns to its start state after every
// terminator.

module version_string_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] ch
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] valid_res, [7:1] zero
);
   import vsc_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_ch_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_res_ff;
   logic              out_free, is_term, advance, verdict;
   vsc_step_type      step;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign is_term    = (in_ch_ff == CH_NUL);
   assign advance    = in_valid_ff && (!is_term || out_free);
   assign req_tready = !in_valid_ff || advance;

   assign step.step = advance;
   assign step.ch   = in_ch_ff;

   vsc_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_in (step),
      .verdict (verdict)
   );

   // input register
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ch_ff <= req_tdata;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance && is_term) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_term) begin
         rsp_res_ff <= verdict;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_res_ff};

endmodule

>>> hdl/vsc_parser.sv
// vsc_parser: phase register and per-byte transition logic
// depends on vsc_pkg
`timescale 1ns / 1ps

module vsc_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  vsc_pkg::vsc_step_type step_in,
   output logic                 verdict
);
   import vsc_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               zero_ff, zero_in;
   logic               is_dec, is_suffix;
   logic [CHAR_W-1:0]  c;

   assign c = step_in.ch;

   always_comb begin
      is_dec    = c inside {[CH_ZERO:CH_NINE]};
      is_suffix = c inside {[CH_ZERO:CH_NINE], [CH_UPPER_A:CH_UPPER_Z],
                            [CH_LOWER_A:CH_LOWER_Z], CH_MINUS, CH_DOT};
   end

   // verdict of a terminator seen in the current phase
   assign verdict = (phase_ff == PH_PAT_MORE) || (phase_ff == PH_SUF_MORE);

   always_comb begin
      phase_in = phase_ff;
      zero_in  = zero_ff;
      if (c == CH_NUL) begin
         phase_in = PH_MAJ_FIRST;
         zero_in  = 1'b0;
      end else begin
         case (phase_ff)
            PH_MAJ_FIRST, PH_MIN_FIRST, PH_PAT_FIRST: begin
               if (is_dec) begin
                  phase_in = phase_ff + 4'd1;
                  zero_in  = (c == CH_ZERO);
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_MAJ_MORE, PH_MIN_MORE: begin
               if (is_dec) begin
                  phase_in = zero_ff ? PH_ERROR : phase_ff;
               end else if (c == CH_DOT) begin
                  phase_in = phase_ff + 4'd1;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_PAT_MORE: begin
               if (is_dec) begin
                  phase_in = zero_ff ? PH_ERROR : phase_ff;
               end else if (c == CH_MINUS || c == CH_PLUS) begin
                  phase_in = PH_SUF_FIRST;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_SUF_FIRST, PH_SUF_MORE: begin
               phase_in = is_suffix ? PH_SUF_MORE : PH_ERROR;
            end
            default: begin
               phase_in = PH_ERROR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAJ_FIRST;
         zero_ff  <= 1'b0;
      end else if (step_in.step) begin
         phase_ff <= phase_in;
         zero_ff  <= zero_in;
      end
   end

endmodule

>>> verif/tb.sv
// tb: self-checking bench for version_string_checker, bytes in and verdicts out
// depends on vsc_pkg and the version_string_checker rtl; predicts each verdict itself
`timescale 1ns / 1ps

module tb;
   import vsc_pkg::*;

   localparam int TARGET_CHARS  = 1400;
   localparam int IDLE_LIMIT    = 5000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 20;

   typedef struct {
      logic [CHAR_W-1:0] ch;
      bit                drain;
   } queued_char_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;

   queued_char_type   char_queue[$];
   logic              expected_verdicts[$];
   logic [CHAR_W-1:0] text_buf[$];
   int                chars_queued = 0;
   int                error_count  = 0;

   // predictor state
   logic [PHASE_W-1:0] pred_phase = PH_MAJ_FIRST;
   bit                 pred_zero  = 1'b0;

   // sender and receiver pacing
   int  req_gap     = 0;
   bit  req_burst   = 1'b0;
   int  rsp_wait    = 0;
   bit  rsp_burst   = 1'b0;
   int  hold_left   = 0;
   int  verdicts_seen = 0;
   logic rsp_ready_next;
   logic verdict_exp;
   int  idle_cycles = 0;

   version_string_checker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] ch
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // [0] valid_res, [7:1] zero
   );

   always #2 clock = ~clock;

   function automatic bit is_digit(input logic [CHAR_W-1:0] ch);
      return ch >= CH_ZERO && ch <= CH_NINE;
   endfunction

   function automatic bit is_suffix_char(input logic [CHAR_W-1:0] ch);
      return is_digit(ch) || (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ||
             (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) || ch == CH_MINUS || ch == CH_DOT;
   endfunction

   // advance the predicted parser by one accepted byte
   task automatic parse_char(input logic [CHAR_W-1:0] ch);
      if (ch == CH_NUL) begin
         expected_verdicts.push_back(pred_phase == PH_PAT_MORE || pred_phase == PH_SUF_MORE);
         pred_phase = PH_MAJ_FIRST;
         pred_zero  = 1'b0;
      end else begin
         case (pred_phase)
            PH_MAJ_FIRST, PH_MIN_FIRST, PH_PAT_FIRST: begin
               if (!is_digit(ch)) begin
                  pred_phase = PH_ERROR;
               end else begin
                  pred_zero  = (ch == CH_ZERO);
                  pred_phase = pred_phase + 1'b1;
               end
            end
            PH_MAJ_MORE, PH_MIN_MORE, PH_PAT_MORE: begin
               if (is_digit(ch)) begin
                  if (pred_zero) pred_phase = PH_ERROR;
               end else if (pred_phase != PH_PAT_MORE) begin
                  pred_phase = (ch == CH_DOT) ? pred_phase + 1'b1 : PH_ERROR;
               end else begin
                  pred_phase = (ch == CH_MINUS || ch == CH_PLUS) ? PH_SUF_FIRST : PH_ERROR;
               end
            end
            PH_SUF_FIRST, PH_SUF_MORE: begin
               pred_phase = is_suffix_char(ch) ? PH_SUF_MORE : PH_ERROR;
            end
            default: begin
               pred_phase = PH_ERROR;
            end
         endcase
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic push_char(input logic [CHAR_W-1:0] ch, input bit drain);
      queued_char_type item;
      item.ch    = ch;
      item.drain = drain;
      char_queue.push_back(item);
      chars_queued++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0);
      push_char(CH_NUL, 1'b0);
   endtask

   // number with occasional leading zero
   task automatic add_number();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) begin
         text_buf.push_back(CH_ZERO);
      end else if (r == 1) begin
         text_buf.push_back(CH_ZERO);
         text_buf.push_back(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
      end else begin
         text_buf.push_back(CHAR_W'(CH_ZERO + $urandom_range(1, 9)));
         repeat ($urandom_range(0, 3))
            text_buf.push_back(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
      end
   endtask

   task automatic add_suffix_char();
      case ($urandom_range(0, 4))
         0: text_buf.push_back(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
         1: text_buf.push_back(CHAR_W'(CH_UPPER_A + $urandom_range(0, 25)));
         2: text_buf.push_back(CHAR_W'(CH_LOWER_A + $urandom_range(0, 25)));
         3: text_buf.push_back(CH_MINUS);
         default: text_buf.push_back(CH_DOT);
      endcase
   endtask

   task automatic make_version();
      add_number();
      text_buf.push_back(CH_DOT);
      add_number();
      text_buf.push_back(CH_DOT);
      add_number();
      if ($urandom_range(0, 1) == 1) begin
         text_buf.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
         repeat ($urandom_range(0, 5)) add_suffix_char();
      end
   endtask

   task automatic flush_text(input bit drain);
      bit first;
      first = drain;
      foreach (text_buf[i]) begin
         push_char(text_buf[i], first);
         first = 1'b0;
      end
      push_char(CH_NUL, first);
      text_buf.delete();
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_char(req_tdata);
            void'(char_queue.pop_front());
            if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
            req_gap = req_burst ? 0 : $urandom_range(0, 5);
         end
         if (!(req_tvalid && !req_tready)) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (char_queue.size() != 0 &&
                         !(char_queue[0].drain && expected_verdicts.size() != 0)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= char_queue[0].ch;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver pacing
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch($sformatf("unexpected verdict transfer 0x%02h", rsp_tdata));
            end else begin
               verdict_exp = expected_verdicts.pop_front();
               if (rsp_tdata !== {7'b0, verdict_exp})
                  report_mismatch($sformatf("verdict 0x%02h, wanted 0x%02h",
                                            rsp_tdata, {7'b0, verdict_exp}));
            end
            verdicts_seen++;
            if (verdicts_seen == 20 || verdicts_seen == 100) hold_left = HOLD_CYCLES;
            if ($urandom_range(0, 9) == 0) rsp_burst = !rsp_burst;
            rsp_wait = rsp_burst ? 0 : $urandom_range(0, 5);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready_next = 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready_next = 1'b0;
         end else begin
            rsp_ready_next = 1'b1;
         end
         rsp_tready <= rsp_ready_next;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int kind;
      int pos;
      bit first_random;

      // directed strings
      push_char(CH_NUL, 1'b0);          // empty string
      push_text("0.0.0");
      push_text("00");                  // leading zero
      push_text("1.2.3-");              // empty suffix
      push_text("9.0.1+AZaz-.");
      push_char(8'h80, 1'b0);           // non-ascii, then judged invalid
      push_char(8'hff, 1'b0);
      push_char(CH_NUL, 1'b0);

      // random strings, mostly well formed
      first_random = 1'b1;
      while (chars_queued < TARGET_CHARS) begin
         kind = $urandom_range(0, 9);
         if (kind <= 8) make_version();
         if (kind == 7) begin
            pos = $urandom_range(0, text_buf.size() - 1);
            if ($urandom_range(0, 1) == 1) text_buf[pos] = CHAR_W'($urandom_range(1, 255));
            else text_buf.insert(pos, CHAR_W'($urandom_range(1, 255)));
         end else if (kind == 8) begin
            pos = $urandom_range(0, text_buf.size() - 1);
            while (text_buf.size() > pos) void'(text_buf.pop_back());
         end else if (kind == 9) begin
            repeat ($urandom_range(0, 6)) text_buf.push_back(CHAR_W'($urandom_range(1, 255)));
         end
         flush_text(first_random || $urandom_range(0, 29) == 0);
         first_random = 1'b0;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (char_queue.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
